// File: rtl/core/equal_power_stereo_panner_top_assert.svh
// Assertion macros shared by the panner RTL files.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef EQUAL_POWER_STEREO_PANNER_TOP_ASSERT_SVH
`define EQUAL_POWER_STEREO_PANNER_TOP_ASSERT_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent holds.
`define EPSP_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define EPSP_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/epsp_pkg.sv
// Shared types and constants of the equal-power stereo panner.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package epsp_pkg;

    // Default values for the top-level parameters.
    localparam int QUARTER_STEPS_DEF = 2048;
    localparam int SAMPLE_BITS_DEF   = 24;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GAIN    = 2'd1;

    // Reset values of the gain state.
    localparam logic [3:0]  BLOCK_LOG2_RESET = 4'd6;
    localparam logic [31:0] LEVEL_RESET      = 32'h4000_0000;

    // Layout of one queue word; the sample sits above the fixed part.
    localparam int ROM_R_LSB     = 0;
    localparam int ROM_L_LSB     = 16;
    localparam int BS_BIT        = 32;
    localparam int TARGET_LSB    = 33;
    localparam int ENTRY_FIXED_W = 49;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    // Back-end sequencer: four multiplier steps and a final output step.
    typedef enum logic [2:0] {
        BK_GL,
        BK_GR,
        BK_OL,
        BK_OR,
        BK_FIN
    } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/epsp_queue.sv
// Short first-in first-out queue that decouples the front from the back.
// Uses q_status_t from epsp_pkg and the assertion macros header.
`default_nettype none
`include "equal_power_stereo_panner_top_assert.svh"

module epsp_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = epsp_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   wdata,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        rdata,
    output epsp_pkg::q_status_t     stat
);
    import epsp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage; no reset is needed on the payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata          = store_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));

    `EPSP_ASSERT_IMP(a_no_overflow, clk, rst_n, push, count_reg != CNT_W'(DEPTH),
        "word pushed into a full queue")
    `EPSP_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_reg != '0,
        "word popped from an empty queue")
    `EPSP_ASSERT_NXT(a_count_hold, clk, rst_n, push == pop, count_reg == $past(count_reg),
        "fill count moved without a net push or pop")

endmodule

`default_nettype wire

// File: rtl/core/epsp_front.sv
// Front end: accepts input words, maps the pan position to a table index and reads the sine table.
// Depends on epsp_pkg; feeds epsp_queue.
`default_nettype none

module epsp_front #(
    parameter int QUARTER_STEPS = epsp_pkg::QUARTER_STEPS_DEF,
    parameter int SAMPLE_BITS   = epsp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        in_valid,
    output logic                                             in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]               sample_in,
    input  wire logic signed [15:0]                          pan_pos,
    input  wire logic [15:0]                                 target_gain,
    input  wire logic                                        block_start,
    output logic                                             q_push,
    output logic [epsp_pkg::ENTRY_FIXED_W+SAMPLE_BITS-1:0]   q_wdata,
    input  wire epsp_pkg::q_status_t                         q_stat
);
    import epsp_pkg::*;

    localparam int IDX_W = $clog2(QUARTER_STEPS + 1);
    localparam int NUM_W = 16 + IDX_W + 1;
    localparam int SH_W  = NUM_W - 15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [NUM_W-1:0] PAN_SCALE  = NUM_W'(QUARTER_STEPS);
    localparam logic signed [NUM_W-1:0] PAN_OFFSET = NUM_W'(QUARTER_STEPS * 16384 + 16384);

    // One sine table entry in Q1.15, from an 11-term Taylor series in Q2.30.
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] tx;
        logic [63:0] ux;
        logic signed [63:0] sum;
        x   = (HALF_PI_Q30 * 64'(i) + 64'(QUARTER_STEPS / 2)) / 64'(QUARTER_STEPS);
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed(x);
        for (int k = 1; k <= 10; k++)
        begin
            tx = (t * x2) >> 30;
            case (k)
                1:       t = tx / 64'd6;
                2:       t = tx / 64'd20;
                3:       t = tx / 64'd42;
                4:       t = tx / 64'd72;
                5:       t = tx / 64'd110;
                6:       t = tx / 64'd156;
                7:       t = tx / 64'd210;
                8:       t = tx / 64'd272;
                9:       t = tx / 64'd342;
                10:      t = tx / 64'd420;
                default: t = 64'd0;
            endcase
            if ((k % 2) == 1)
                sum = sum - $signed(t);
            else
                sum = sum + $signed(t);
        end
        if (sum < 0)
            sum = 0;
        ux = ($unsigned(sum) + 64'd16384) >> 15;
        return ux[15:0];
    endfunction

    // Quarter-wave sine table, fixed at elaboration.
    logic [15:0] sine_tbl [QUARTER_STEPS+1];

    for (genvar gi = 0; gi <= QUARTER_STEPS; gi++)
    begin : g_sine
        assign sine_tbl[gi] = sine_entry(gi);
    end

    logic signed [NUM_W-1:0]       pan_ext;
    logic signed [NUM_W-1:0]       num;
    logic [SH_W-1:0]               num_sh;
    logic [IDX_W-1:0]              idx_calc;
    logic                          accept;
    logic                          f_valid_reg, f_valid_next;
    logic signed [SAMPLE_BITS-1:0] f_sample_reg;
    logic [15:0]                   f_target_reg;
    logic                          f_bs_reg;
    logic [IDX_W-1:0]              f_idx_reg;

    // Pan position to table index, rounded and clamped to the quarter wave.
    assign pan_ext = NUM_W'(pan_pos);
    assign num     = pan_ext * PAN_SCALE + PAN_OFFSET;
    assign num_sh  = num[NUM_W-1:15];

    always_comb
    begin
        if (num[NUM_W-1])
            idx_calc = '0;
        else if (num_sh > SH_W'(QUARTER_STEPS))
            idx_calc = IDX_W'(QUARTER_STEPS);
        else
            idx_calc = num_sh[IDX_W-1:0];
    end

    // Front holding register: filled on accept, emptied into the queue.
    assign q_push       = f_valid_reg && !q_stat.full;
    assign in_stall     = f_valid_reg && q_stat.full;
    assign accept       = in_valid && !in_stall;
    assign f_valid_next = accept || (f_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_sample_reg <= sample_in;
            f_target_reg <= target_gain;
            f_bs_reg     <= block_start;
            f_idx_reg    <= idx_calc;
        end
    end

    // Queue word: the queue storage registers the two table reads.
    assign q_wdata = {f_sample_reg, f_target_reg, f_bs_reg,
                      sine_tbl[IDX_W'(QUARTER_STEPS) - f_idx_reg], sine_tbl[f_idx_reg]};

endmodule

`default_nettype wire

// File: rtl/core/epsp_back.sv
// Back end: gain ramp state, one shared multiplier for the four products, saturation and output register.
// Depends on epsp_pkg and the assertion macros header; consumes words from epsp_queue.
`default_nettype none
`include "equal_power_stereo_panner_top_assert.svh"

module epsp_back #(
    parameter int SAMPLE_BITS = epsp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_we,
    input  wire logic [epsp_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [epsp_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  wire logic [epsp_pkg::ENTRY_FIXED_W+SAMPLE_BITS-1:0] q_rdata,
    input  wire epsp_pkg::q_status_t                         q_stat,
    output logic                                             q_pop,
    output logic                                             out_valid,
    input  wire logic                                        out_stall,
    output logic signed [SAMPLE_BITS-1:0]                    left_out,
    output logic signed [SAMPLE_BITS-1:0]                    right_out
);
    import epsp_pkg::*;

    localparam int G_W = 18;
    localparam int A_W = 33;
    localparam int B_W = G_W + 1;
    localparam int P_W = A_W + B_W;
    localparam logic [P_W-1:0]        G_RND   = P_W'(64'd1 << 29);
    localparam logic signed [P_W-1:0] OUT_RND = P_W'(16384);
    localparam logic signed [P_W-1:0] OUT_HI  = P_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [P_W-1:0] OUT_LO  = -OUT_HI - P_W'(1);

    // Round a product to Q.15 output scale and saturate to the sample width.
    function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] s;
        s = p + OUT_RND;
        s = s >>> 15;
        if (s > OUT_HI)
            return OUT_HI[SAMPLE_BITS-1:0];
        else if (s < OUT_LO)
            return OUT_LO[SAMPLE_BITS-1:0];
        else
            return s[SAMPLE_BITS-1:0];
    endfunction

    // Fields of the queue head word.
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic [15:0]                   q_target;
    logic                          q_bs;
    logic [15:0]                   q_rom_l;
    logic [15:0]                   q_rom_r;

    assign q_sample = q_rdata[ENTRY_FIXED_W +: SAMPLE_BITS];
    assign q_target = q_rdata[TARGET_LSB +: 16];
    assign q_bs     = q_rdata[BS_BIT];
    assign q_rom_l  = q_rdata[ROM_L_LSB +: 16];
    assign q_rom_r  = q_rdata[ROM_R_LSB +: 16];

    back_state_t              state_reg, state_next;
    logic [31:0]              level_reg, level_next;
    logic signed [32:0]       slope_reg, slope_next;
    logic [3:0]               bsl2_reg, bsl2_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [P_W-1:0]    mul_p;
    logic signed [P_W-1:0]    prod_reg;
    logic [P_W-1:0]           g_sum;
    logic [G_W-1:0]           g_l_reg;
    logic [G_W-1:0]           g_r_reg;
    logic [SAMPLE_BITS-1:0]   left_hold_reg;
    logic [SAMPLE_BITS-1:0]   left_out_reg;
    logic [SAMPLE_BITS-1:0]   right_out_reg;
    logic                     fin_fire;
    logic                     slope_load;
    logic signed [33:0]       diff;
    logic signed [33:0]       lvl_sum;

    // Sequencer and multiplier operand selection.
    always_comb
    begin
        state_next = state_reg;
        mul_a      = {1'b0, level_reg};
        mul_b      = {{(B_W - 16){1'b0}}, q_rom_l};
        fin_fire   = 1'b0;
        slope_load = 1'b0;
        case (state_reg)
            BK_GL:
            begin
                if (q_stat.not_empty)
                begin
                    slope_load = q_bs;
                    state_next = BK_GR;
                end
            end
            BK_GR:
            begin
                mul_b      = {{(B_W - 16){1'b0}}, q_rom_r};
                state_next = BK_OL;
            end
            BK_OL:
            begin
                mul_a      = A_W'(q_sample);
                mul_b      = {1'b0, g_l_reg};
                state_next = BK_OR;
            end
            BK_OR:
            begin
                mul_a      = A_W'(q_sample);
                mul_b      = {1'b0, g_r_reg};
                state_next = BK_FIN;
            end
            BK_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fin_fire   = 1'b1;
                    state_next = BK_GL;
                end
            end
            default:
            begin
                state_next = BK_GL;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign g_sum = $unsigned(prod_reg) + G_RND;
    assign q_pop = fin_fire;

    // Slope toward the target, and the level step after each word.
    assign diff    = $signed({3'b000, q_target, 15'b0}) - $signed({2'b00, level_reg});
    assign lvl_sum = $signed({2'b00, level_reg}) + 34'(slope_reg);

    always_comb
    begin
        slope_next = slope_reg;
        level_next = level_reg;
        bsl2_next  = bsl2_reg;
        if (slope_load)
        begin
            slope_next = 33'(diff >>> bsl2_reg);
        end
        if (fin_fire)
        begin
            if (lvl_sum[33])
                level_next = '0;
            else if (lvl_sum[32])
                level_next = '1;
            else
                level_next = lvl_sum[31:0];
        end
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE_LOG2: bsl2_next  = cfg_data[3:0];
                CFG_INITIAL_GAIN:    level_next = {1'b0, cfg_data, 15'b0};
                default:             bsl2_next  = bsl2_reg;
            endcase
        end
    end

    // Output register: loaded on the final step, emptied when taken.
    always_comb
    begin
        if (fin_fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_GL;
            level_reg     <= LEVEL_RESET;
            slope_reg     <= '0;
            bsl2_reg      <= BLOCK_LOG2_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            slope_reg     <= slope_next;
            bsl2_reg      <= bsl2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers around the shared multiplier.
    always_ff @(posedge clk)
    begin
        if (state_reg != BK_FIN)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == BK_GR)
        begin
            g_l_reg <= g_sum[30 +: G_W];
        end
        if (state_reg == BK_OL)
        begin
            g_r_reg <= g_sum[30 +: G_W];
        end
        if (state_reg == BK_OR)
        begin
            left_hold_reg <= sat_out(prod_reg);
        end
        if (fin_fire)
        begin
            left_out_reg  <= left_hold_reg;
            right_out_reg <= sat_out(prod_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    `EPSP_ASSERT_NXT(a_level_quiet, clk, rst_n, !fin_fire && !cfg_we, $stable(level_reg),
        "gain level moved outside a final step or a configuration write")
    `EPSP_ASSERT_IMP(a_pop_has_word, clk, rst_n, q_pop, q_stat.not_empty,
        "final step reached without a queued word")
    `EPSP_ASSERT_IMP(a_gr_after_gl, clk, rst_n, state_reg == BK_GR, $past(state_reg) == BK_GL,
        "second gain product not preceded by the first")

endmodule

`default_nettype wire

// File: rtl/core/equal_power_stereo_panner_top.sv
// Equal-power stereo panner, top level: front end, word queue and back end.
// Path: an accepted input word passes the front holding register, the word queue, the back end's
// sequencer steps and the output register before out_valid. The back end finishes one word before
// it starts the next: its single multiplier forms four products per word in turn, plus one output step.
// Reset: asynchronous, active low; clears the queue and handshakes, sets block_size_log2 to 6,
// the gain level to 1.0 (Q2.30) and the slope to zero.
`default_nettype none

module equal_power_stereo_panner_top #(
    parameter int QUARTER_STEPS = epsp_pkg::QUARTER_STEPS_DEF,
    parameter int SAMPLE_BITS   = epsp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
    input  wire logic signed [15:0]                pan_pos,
    input  wire logic [15:0]                       target_gain,
    input  wire logic                              block_start,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [SAMPLE_BITS-1:0]          left_out,
    output logic signed [SAMPLE_BITS-1:0]          right_out,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [epsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [epsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import epsp_pkg::*;

    localparam int ENTRY_W = ENTRY_FIXED_W + SAMPLE_BITS;

    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;
    q_status_t          q_stat;
    logic               cfg_we;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    epsp_front #(
        .QUARTER_STEPS (QUARTER_STEPS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .pan_pos     (pan_pos),
        .target_gain (target_gain),
        .block_start (block_start),
        .q_push      (q_push),
        .q_wdata     (q_wdata),
        .q_stat      (q_stat)
    );

    epsp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    epsp_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_rdata   (q_rdata),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule

`default_nettype wire
